// ----- hdl/jbsd_pkg.sv -----
// jbsd_pkg: shared types, codes and jamo tables of the johab byte stream decoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package jbsd_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_KSX     = 2'd1,
    KIND_INVALID = 2'd2,
    KIND_TRUNC   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_CHAR   = 2'd0,
    OP_TRUNC  = 2'd1,
    OP_HANGUL = 2'd2,
    OP_KSX    = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] lead;
    logic [7:0] data;
  } pair_t;

  localparam logic [7:0] LeadHangulEnd = 8'hd8;
  localparam logic [4:0] PosFillInit   = 5'd1;
  localparam logic [4:0] PosFillMed    = 5'd2;
  localparam logic [4:0] PosFillFin    = 5'd1;
  localparam logic [15:0] SyllableBase = 16'hac00;
  localparam logic [15:0] JamoBase     = 16'h3100;
  localparam logic [15:0] IdeoSpace    = 16'h3000;

  localparam logic [7:0] InitJamo [32] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h34, 8'h37, 8'h38, 8'h39,
    8'h41, 8'h42, 8'h43, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
    8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] MedJamo [32] = '{
    8'h00, 8'h00, 8'h00, 8'h4f, 8'h50, 8'h51, 8'h52, 8'h53,
    8'h00, 8'h00, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59,
    8'h00, 8'h00, 8'h5a, 8'h5b, 8'h5c, 8'h5d, 8'h5e, 8'h5f,
    8'h00, 8'h00, 8'h60, 8'h61, 8'h62, 8'h63, 8'h00, 8'h00};
  localparam logic [7:0] FinJamo [32] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f,
    8'h40, 8'h41, 8'h00, 8'h42, 8'h44, 8'h45, 8'h46, 8'h47,
    8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h00, 8'h00};

  localparam logic [4:0] InitIdx [32] = '{
    5'd0, 5'd0, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5,
    5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13,
    5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd0, 5'd0, 5'd0,
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
  localparam logic [4:0] MedIdx [32] = '{
    5'd0, 5'd0, 5'd0, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4,
    5'd0, 5'd0, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
    5'd0, 5'd0, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16,
    5'd0, 5'd0, 5'd17, 5'd18, 5'd19, 5'd20, 5'd0, 5'd0};
  localparam logic [4:0] FinIdx [32] = '{
    5'd0, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6,
    5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14,
    5'd15, 5'd16, 5'd0, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21,
    5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd0, 5'd0};

endpackage

// ----- hdl/johab_byte_stream_decoder_top.sv -----
// Johab byte stream decoder: one byte in per cycle while the queue has room, one code
// point or flag out per byte that completes a character. A lead byte (0x80 and up) is
// held and gives no result until its trail arrives; a lead on the last byte of a stream
// is flagged truncated. Sustained rate is one byte per cycle while results are taken:
// the front stage classifies a byte in the cycle it is accepted, a queue of QueueDepth
// entries parts it from the back stage, which decodes one entry per cycle when not
// stalled (jamo tables and two constant multiplies) into the output register. A result
// is registered in the queue entry and then in the output register.
// depends on jbsd_pkg, jbsd_front, jbsd_queue, jbsd_back
`timescale 1ns / 1ps

module johab_byte_stream_decoder_top #(
  parameter int unsigned QueueDepth = jbsd_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        stream_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_value_o,
  output logic [1:0]  result_kind_o
);
  import jbsd_pkg::*;

  logic  push, pop, q_full, q_empty;
  pair_t push_data, pop_data;
  kind_e kind;

  jbsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .stream_end_i (stream_end_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  jbsd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_data)
  );

  jbsd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_value_o  (code_value_o),
    .result_kind_o (kind)
  );

  assign result_kind_o = 2'(kind);

endmodule

// ----- hdl/jbsd_front.sv -----
// jbsd_front: accepts bytes, holds a pending lead byte and classifies each transaction
// depends on jbsd_pkg
`timescale 1ns / 1ps

module jbsd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_byte_i,
  input  logic           stream_end_i,
  input  logic           q_full_i,
  output logic           push_o,
  output jbsd_pkg::pair_t push_data_o
);
  import jbsd_pkg::*;

  logic       lead_pending_q, lead_pending_d;
  logic [7:0] lead_byte_q, lead_byte_d;
  logic       accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    lead_pending_d   = lead_pending_q;
    lead_byte_d      = lead_byte_q;
    push_o           = 1'b0;
    push_data_o.op   = OP_CHAR;
    push_data_o.lead = lead_byte_q;
    push_data_o.data = in_byte_i;
    if (accept) begin
      if (lead_pending_q) begin
        push_o         = 1'b1;
        push_data_o.op = (lead_byte_q < LeadHangulEnd) ? OP_HANGUL : OP_KSX;
        lead_pending_d = 1'b0;
        lead_byte_d    = 8'h00;
      end else if (!in_byte_i[7]) begin
        push_o = 1'b1;
      end else if (stream_end_i) begin
        push_o         = 1'b1;
        push_data_o.op = OP_TRUNC;
      end else begin
        lead_pending_d = 1'b1;
        lead_byte_d    = in_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_pending_q <= 1'b0;
      lead_byte_q    <= 8'h00;
    end else begin
      lead_pending_q <= lead_pending_d;
      lead_byte_q    <= lead_byte_d;
    end
  end

endmodule

// ----- hdl/jbsd_queue.sv -----
// jbsd_queue: short first-in first-out queue of classified transactions
// depends on jbsd_pkg
`timescale 1ns / 1ps

module jbsd_queue #(
  parameter int unsigned Depth = jbsd_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jbsd_pkg::pair_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output jbsd_pkg::pair_t pop_data_o
);
  import jbsd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  pair_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o     = (count_q == FullCnt);
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/jbsd_back.sv -----
// jbsd_back: while not stalled, decodes one queued transaction per cycle into a register
// depends on jbsd_pkg
`timescale 1ns / 1ps

module jbsd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  jbsd_pkg::pair_t q_data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [15:0]     code_value_o,
  output jbsd_pkg::kind_e result_kind_o
);
  import jbsd_pkg::*;

  logic        out_valid_q;
  logic [15:0] code_q, code_d;
  kind_e       kind_q, kind_d;

  logic [7:0]  c, t;
  logic [4:0]  pi, pm, pf, fin_sel;
  logic        fi, fm, ff, li, lm, lf;
  logic [15:0] syllable;
  logic [8:0]  row;
  logic [7:0]  col;
  logic        ks_bad;

  assign c  = q_data_i.lead;
  assign t  = q_data_i.data;
  assign pi = c[6:2];
  assign pm = {c[1:0], t[7:5]};
  assign pf = t[4:0];
  assign fi = (pi == PosFillInit);
  assign fm = (pm == PosFillMed);
  assign ff = (pf == PosFillFin);
  assign li = (InitJamo[pi] != 8'h00);
  assign lm = (MedJamo[pm] != 8'h00);
  assign lf = (FinJamo[pf] != 8'h00);
  assign fin_sel  = ff ? 5'd0 : FinIdx[pf];
  assign syllable = SyllableBase + 16'(InitIdx[pi]) * 16'd588
                  + 16'(MedIdx[pm]) * 16'd28 + 16'(fin_sel);

  assign pop_o = !q_empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    ks_bad = (c == 8'hd8) || (c == 8'hdf) || (c > 8'hf9) || (t < 8'h31)
           || (t inside {[8'h80:8'h90]}) || (t[6:0] == 7'h7f)
           || ((c == 8'hda) && (t inside {[8'ha1:8'hd3]}));
    row = (c < 8'he0) ? {c - 8'hd9, 1'b0} : {c, 1'b0} - 9'h197;
    col = (t < 8'h91) ? t - 8'h31 : t - 8'h43;
    if (col >= 8'h5e) begin
      row = row + 9'd1;
      col = col - 8'h5e;
    end
  end

  always_comb begin
    code_d = 16'h0000;
    kind_d = KIND_INVALID;
    case (q_data_i.op)
      OP_CHAR: begin
        code_d = {8'h00, t};
        kind_d = KIND_CHAR;
      end
      OP_TRUNC: begin
        kind_d = KIND_TRUNC;
      end
      OP_HANGUL: begin
        if (!(fi || li) || !(fm || lm) || !(ff || lf)) begin
          kind_d = KIND_INVALID;
        end else if (fi) begin
          if (fm) begin
            code_d = ff ? IdeoSpace : (JamoBase | {8'h00, FinJamo[pf]});
            kind_d = KIND_CHAR;
          end else if (ff) begin
            code_d = JamoBase | {8'h00, MedJamo[pm]};
            kind_d = KIND_CHAR;
          end
        end else if (fm) begin
          if (ff) begin
            code_d = JamoBase | {8'h00, InitJamo[pi]};
            kind_d = KIND_CHAR;
          end
        end else begin
          code_d = syllable;
          kind_d = KIND_CHAR;
        end
      end
      OP_KSX: begin
        if (!ks_bad) begin
          code_d = {row[7:0] + 8'h21, col + 8'h21};
          kind_d = KIND_KSX;
        end
      end
      default: begin
        kind_d = KIND_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      code_q <= code_d;
      kind_q <= kind_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_value_o  = code_q;
  assign result_kind_o = kind_q;

endmodule

// ----- hdl/jbsd_checker.sv -----
// jbsd_checker: port level checks of the johab byte stream decoder, bound to the top
// depends on jbsd_pkg and johab_byte_stream_decoder_top
`timescale 1ns / 1ps

module jbsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  in_byte_i,
  input logic        stream_end_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] code_value_o,
  input logic [1:0]  result_kind_o
);
  import jbsd_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_value_o)
      && $stable(result_kind_o))
    else $error("stalled result changed");

  // flagged results carry no code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KIND_TRUNC || result_kind_o == KIND_INVALID)
      |-> code_value_o == 16'h0000)
    else $error("flag result with nonzero code");

  // row and column of a lookup code start at 0x21
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_KSX
      |-> code_value_o[15:8] >= 8'h21 && code_value_o[7:0] >= 8'h21)
    else $error("lookup code out of range");

  // an ascii byte into an empty pipeline passes the queue and raises out_valid_o
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && out_ready_i && in_ready_o ##1 !out_valid_o && out_ready_i
      && in_valid_i && in_ready_o && !in_byte_i[7] && !$past(in_valid_i)
      |=> ##1 out_valid_o)
    else $error("ascii byte not delivered");

endmodule

bind johab_byte_stream_decoder_top jbsd_checker u_jbsd_checker (.*);

// ----- bench/johab_byte_stream_decoder_top_tb.sv -----
// testbench for johab_byte_stream_decoder_top: directed and random byte streams,
// an in-bench decoder predicts each code point or flag; depends on jbsd_pkg and the rtl
`timescale 1ns / 1ps

module johab_byte_stream_decoder_top_tb;
  import jbsd_pkg::*;

  localparam int CycleLimit = 500000;
  localparam logic [7:0] FirstKsLead = 8'hd8;

  // jamo low bytes per 5-bit position code, zero where the code has no letter
  localparam logic [7:0] InitialJamo [32] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h34, 8'h37, 8'h38, 8'h39,
    8'h41, 8'h42, 8'h43, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
    8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] VowelJamo [32] = '{
    8'h00, 8'h00, 8'h00, 8'h4f, 8'h50, 8'h51, 8'h52, 8'h53,
    8'h00, 8'h00, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59,
    8'h00, 8'h00, 8'h5a, 8'h5b, 8'h5c, 8'h5d, 8'h5e, 8'h5f,
    8'h00, 8'h00, 8'h60, 8'h61, 8'h62, 8'h63, 8'h00, 8'h00};
  localparam logic [7:0] FinalJamo [32] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f,
    8'h40, 8'h41, 8'h00, 8'h42, 8'h44, 8'h45, 8'h46, 8'h47,
    8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h00, 8'h00};

  typedef struct {
    logic [15:0] code;
    kind_e       kind;
  } decoded_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = 8'h00;
  logic        stream_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] code_value_o;
  logic [1:0]  result_kind_o;

  decoded_t    pending_codes[$];
  bit          lead_held = 1'b0;
  logic [7:0]  held_lead = 8'h00;
  bit          idle_on = 1'b1;
  int          hold_gen = 0;
  int          hold_len = 0;
  int          errors = 0;
  int          bytes_sent = 0;
  int          results_seen = 0;
  int          kind_seen [4] = '{0, 0, 0, 0};
  int          cycles = 0;

  johab_byte_stream_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .stream_end_i  (stream_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_value_o  (code_value_o),
    .result_kind_o (result_kind_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_codes.size());
      $display("johab_byte_stream_decoder_top test failed");
      $finish;
    end
  end

  // johab pair split into initial, medial and final position codes
  function automatic decoded_t decode_hangul_pair(input logic [7:0] c, input logic [7:0] t);
    decoded_t   res;
    logic [4:0] pi, pm, pf;
    bit         fi, fm, ff, li, lm, lf;
    int         vidx, fidx;
    pi = c[6:2];
    pm = {c[1:0], t[7:5]};
    pf = t[4:0];
    fi = (pi == 5'd1);
    fm = (pm == 5'd2);
    ff = (pf == 5'd1);
    li = (InitialJamo[pi] != 8'h00);
    lm = (VowelJamo[pm] != 8'h00);
    lf = (FinalJamo[pf] != 8'h00);
    res.code = 16'h0000;
    res.kind = KIND_INVALID;
    if (!(fi || li) || !(fm || lm) || !(ff || lf)) begin
      res.kind = KIND_INVALID;
    end else if (fi) begin
      if (fm) begin
        res.code = ff ? 16'h3000 : {8'h31, FinalJamo[pf]};
        res.kind = KIND_CHAR;
      end else if (ff) begin
        res.code = {8'h31, VowelJamo[pm]};
        res.kind = KIND_CHAR;
      end
    end else if (fm) begin
      if (ff) begin
        res.code = {8'h31, InitialJamo[pi]};
        res.kind = KIND_CHAR;
      end
    end else begin
      // vowel codes come in runs of up to six, two unused codes between runs
      vidx = int'(pm) - 3 - 2 * int'(pm >> 3);
      fidx = ff ? 0 : ((pf <= 5'd17) ? int'(pf) - 1 : int'(pf) - 2);
      res.code = 16'(32'hac00 + (int'(pi) - 2) * 588 + vidx * 28 + fidx);
      res.kind = KIND_CHAR;
    end
    return res;
  endfunction

  function automatic decoded_t decode_ksx_pair(input logic [7:0] c, input logic [7:0] t);
    decoded_t res;
    int       row, col;
    res.code = 16'h0000;
    res.kind = KIND_INVALID;
    if (!(c == 8'hd8 || c == 8'hdf || c > 8'hf9 || t < 8'h31 ||
          (t >= 8'h80 && t < 8'h91) || t[6:0] == 7'h7f ||
          (c == 8'hda && t >= 8'ha1 && t <= 8'hd3))) begin
      row = (c < 8'he0) ? 2 * (int'(c) - 'hd9) : 2 * int'(c) - 'h197;
      col = (t < 8'h91) ? int'(t) - 'h31 : int'(t) - 'h43;
      if (col >= 'h5e) begin
        row = row + 1;
        col = col - 'h5e;
      end
      res.code = {8'(row + 'h21), 8'(col + 'h21)};
      res.kind = KIND_KSX;
    end
    return res;
  endfunction

  // advances the held-lead state by one byte, returns whether a result follows
  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     output decoded_t res);
    logic [7:0] c;
    res.code = {8'h00, b};
    res.kind = KIND_CHAR;
    if (lead_held) begin
      c = held_lead;
      lead_held = 1'b0;
      held_lead = 8'h00;
      res = (c < FirstKsLead) ? decode_hangul_pair(c, b) : decode_ksx_pair(c, b);
      return 1'b1;
    end
    if (b < 8'h80) begin
      return 1'b1;
    end
    if (last) begin
      res.code = 16'h0000;
      res.kind = KIND_TRUNC;
      return 1'b1;
    end
    lead_held = 1'b1;
    held_lead = b;
    return 1'b0;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    decoded_t res;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_byte_i    <= b;
    stream_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    if (decode_byte(b, last, res)) pending_codes.push_back(res);
    bytes_sent++;
  endtask

  task automatic send_pair(input logic [7:0] lead, input logic [7:0] trail,
                           input logic last);
    send_byte(lead, 1'b0);
    send_byte(trail, last);
  endtask

  task automatic send_jamo(input logic [4:0] pi, input logic [4:0] pm,
                           input logic [4:0] pf, input logic last);
    send_pair({1'b1, pi, pm[4:3]}, {pm[2:0], pf}, last);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_codes.size() != 0);
  endtask

  task automatic send_random_item();
    logic [4:0] pi, pm, pf;
    logic [7:0] lead, trail;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send_byte(8'($urandom_range(0, 127)), $urandom_range(0, 15) == 0);
    end else if (pick < 55) begin
      pi = 5'($urandom_range(1, 20));
      if ($urandom_range(0, 7) == 0) pm = 5'd2;
      else do pm = 5'($urandom_range(3, 29)); while (VowelJamo[pm] == 8'h00);
      if ($urandom_range(0, 5) == 0) pf = 5'd1;
      else do pf = 5'($urandom_range(2, 29)); while (FinalJamo[pf] == 8'h00);
      send_jamo(pi, pm, pf, $urandom_range(0, 15) == 0);
    end else if (pick < 75) begin
      lead = 8'($urandom_range('hd9, 'hf9));
      if (lead == 8'hdf) lead = 8'he0;
      trail = $urandom_range(0, 1) ? 8'($urandom_range('h31, 'h7e))
                                   : 8'($urandom_range('h91, 'hfe));
      send_pair(lead, trail, $urandom_range(0, 15) == 0);
    end else if (pick < 85) begin
      send_byte(8'($urandom_range('h80, 'hff)), 1'b1);
    end else begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic test_ascii_and_truncation();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'hff, 1'b1);
  endtask

  task automatic test_hangul_cases();
    send_jamo(5'd2, 5'd3, 5'd1, 1'b0);
    send_jamo(5'd20, 5'd29, 5'd29, 1'b1);
    send_jamo(5'd1, 5'd2, 5'd1, 1'b0);
    send_jamo(5'd1, 5'd2, 5'd2, 1'b0);
    send_jamo(5'd1, 5'd3, 5'd1, 1'b0);
    send_jamo(5'd2, 5'd2, 5'd1, 1'b0);
    send_jamo(5'd21, 5'd31, 5'd18, 1'b0);
    send_jamo(5'd1, 5'd3, 5'd2, 1'b0);
    send_jamo(5'd2, 5'd2, 5'd2, 1'b0);
  endtask

  task automatic test_ksx_cases();
    send_pair(8'hd9, 8'h31, 1'b0);
    send_pair(8'hf9, 8'hfe, 1'b0);
    send_pair(8'hd8, 8'ha1, 1'b0);
    send_pair(8'hdf, 8'h7f, 1'b0);
    send_pair(8'hfa, 8'h80, 1'b0);
    send_pair(8'hda, 8'ha1, 1'b0);
    send_pair(8'hda, 8'hd4, 1'b0);
    send_pair(8'he0, 8'h30, 1'b1);
  endtask

  // receiver holds off while the sender keeps offering, so the block backs up
  task automatic test_stall_fill();
    int n;
    idle_on  = 1'b0;
    hold_len = 80;
    hold_gen++;
    for (n = 0; n < 20; n++) begin
      if (n % 3 == 0) send_pair(8'he5, 8'(8'h40 + n), 1'b0);
      else send_byte(8'(n + 8'h20), 1'b0);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    int n;
    for (n = 0; n < 20; n++) send_random_item();
    if (lead_held) send_byte(8'h41, 1'b1);
    wait_drained();
    for (n = 0; n < 20; n++) send_random_item();
  endtask

  task automatic test_random_stream(input int n_bytes, input bit with_idle);
    int target;
    target  = bytes_sent + n_bytes;
    idle_on = with_idle;
    while (bytes_sent < target) send_random_item();
    if (lead_held) send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin : result_check
    decoded_t want;
    int       stall_left, hold_left, hold_seen;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        kind_seen[result_kind_o]++;
        if (pending_codes.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, code %h kind %0d",
                   $time, code_value_o, result_kind_o);
        end else begin
          want = pending_codes.pop_front();
          if (code_value_o !== want.code) begin
            errors++;
            $display("%0t: code_value expected %h got %h", $time, want.code, code_value_o);
          end
          if (result_kind_o !== want.kind) begin
            errors++;
            $display("%0t: result_kind expected %0d got %0d",
                     $time, want.kind, result_kind_o);
          end
        end
      end
      if (hold_seen != hold_gen) begin
        hold_seen = hold_gen;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ascii_and_truncation();
    test_hangul_cases();
    test_ksx_cases();
    test_stall_fill();
    test_drain_pause();
    test_random_stream(1250, 1'b1);
    test_random_stream(250, 1'b0);
    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("%0d bytes sent, %0d results checked: char %0d, ksx %0d, invalid %0d, trunc %0d",
             bytes_sent, results_seen, kind_seen[0], kind_seen[1], kind_seen[2],
             kind_seen[3]);
    $display("covered jamo and ks x 1001 corner cases, a long output hold and a drain pause");
    if (errors == 0 && pending_codes.size() == 0) begin
      $display("johab_byte_stream_decoder_top test passed");
    end else begin
      $display("johab_byte_stream_decoder_top test failed");
    end
    $finish;
  end

endmodule
